/* rtl/core/scc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment crossing package
// Widths, item types and verdict codes shared by the crossing pipeline.
// ----------------------------------------------------------------------------
package scc_pkg;

   // coordinate format: signed, 4 fraction bits
   localparam int COORD_BITS = 16;
   localparam int DW    = COORD_BITS + 1;        // coordinate difference
   localparam int PW    = 2 * DW;                // product of two differences
   localparam int SW    = PW + 1;                // sum of two products
   localparam int CLR_W = 12;                    // clearance register
   localparam int C2_W  = 2 * CLR_W;             // squared clearance
   localparam int DQ_W  = (PW > C2_W) ? PW : C2_W;
   localparam int HPW   = 2 * DW;                // partial product of halves
   localparam int CPW   = C2_W + DW;             // clearance partial product
   localparam int LW    = 2 * PW;                // squared cross product
   localparam int RW    = C2_W + PW;             // clearance^2 * length^2
   localparam int CW    = (LW > RW) ? LW : RW;

   localparam logic [CLR_W-1:0] CLR_RESET = CLR_W'(32);

   // four endpoint-to-segment lanes; points are a, b, c, d = 0..3
   localparam int LANES = 4;
   localparam int LANE_P [LANES] = '{2, 3, 0, 1};
   localparam int LANE_S [LANES] = '{0, 0, 2, 2};
   localparam int LANE_E [LANES] = '{1, 1, 3, 3};

   // verdict codes
   localparam logic [1:0] VERDICT_CROSS = 2'd0;
   localparam logic [1:0] VERDICT_IDENT = 2'd1;
   localparam logic [1:0] VERDICT_CLEAR = 2'd2;
   localparam logic [1:0] VERDICT_NONE  = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_start_x;
      logic signed [COORD_BITS-1:0] first_start_y;
      logic signed [COORD_BITS-1:0] first_end_x;
      logic signed [COORD_BITS-1:0] first_end_y;
      logic signed [COORD_BITS-1:0] second_start_x;
      logic signed [COORD_BITS-1:0] second_start_y;
      logic signed [COORD_BITS-1:0] second_end_x;
      logic signed [COORD_BITS-1:0] second_end_y;
   } req_item_type;

   typedef struct packed {
      logic       crosses;
      logic [1:0] verdict;
   } rsp_item_type;

   // per-lane pipeline payloads
   typedef struct packed {
      logic signed [DW-1:0] cx;
      logic signed [DW-1:0] cy;
      logic signed [DW-1:0] wx;
      logic signed [DW-1:0] wy;
      logic signed [DW-1:0] vx;
      logic signed [DW-1:0] vy;
   } diff_lane_type;

   typedef struct packed {
      logic signed [PW-1:0] dxx;
      logic signed [PW-1:0] dyy;
      logic signed [PW-1:0] lxx;
      logic signed [PW-1:0] lyy;
      logic signed [PW-1:0] wxx;
      logic signed [PW-1:0] wyy;
      logic signed [PW-1:0] vxx;
      logic signed [PW-1:0] vyy;
      logic signed [PW-1:0] crx;
      logic signed [PW-1:0] cry;
   } prod_lane_type;

   typedef struct packed {
      logic signed [SW-1:0] dot;
      logic        [PW-1:0] len;
      logic        [PW-1:0] dw;
      logic        [PW-1:0] dv;
      logic signed [SW-1:0] cprod;
   } sum_lane_type;

   typedef struct packed {
      logic [HPW-1:0] hh;
      logic [HPW-1:0] hl;
      logic [HPW-1:0] ll;
      logic [CPW-1:0] ch;
      logic [CPW-1:0] cl;
      logic           proj;
      logic           close;
   } part_lane_type;

   typedef struct packed {
      logic [LW-1:0] lhs;
      logic [RW-1:0] rhs;
      logic          proj;
      logic          close;
   } wide_lane_type;

endpackage

/* rtl/core/segment_crossing_with_clearance_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment crossing with clearance
// Tests whether two segments properly cross, rejecting identical segments
// and pairs with an endpoint closer than the clearance to the other segment.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_item with the two segments and raise start; the item
//   is taken at each clock edge with start high and busy low. busy stays low,
//   so one item can be taken in every cycle.
//   Output: each item gives one result on rsp_item, marked by rsp_strobe
//   for one cycle. Results leave in item order. The receiver cannot
//   stall, so the pipeline never holds. Throughput is one item per
//   cycle; the depth is set by the six register stages: differences,
//   products, sums, distance select with split squaring, partial-product
//   sums, final compare. Configuration: the clearance register is written
//   over csr_valid / csr_ready / csr_data (always ready); the user must
//   write it only while no item is in flight; the block does not enforce it.
//   Reset (synchronous) empties the pipeline and sets the clearance to 32.
// ----------------------------------------------------------------------------
module segment_crossing_with_clearance_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  scc_pkg::req_item_type      req_item,
   output logic                       rsp_strobe,
   output scc_pkg::rsp_item_type      rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [scc_pkg::CLR_W-1:0]  csr_data
);
   import scc_pkg::*;

   localparam int DEPTH = 6;

   // control
   logic [DEPTH-1:0]     valid_ff;
   logic [DEPTH-1:0]     valid_in;
   logic [CLR_W-1:0]     clearance_ff;
   logic [C2_W-1:0]      clr_sq_ff;

   // stage payloads
   logic                 ident1_ff, ident2_ff, ident3_ff, ident4_ff, ident5_ff;
   logic                 ident1_in;
   logic                 proper4_ff, proper5_ff;
   logic                 proper4_in;
   diff_lane_type        diff_ff  [LANES];
   diff_lane_type        diff_in  [LANES];
   prod_lane_type        prod_ff  [LANES];
   prod_lane_type        prod_in  [LANES];
   sum_lane_type         sum_ff   [LANES];
   sum_lane_type         sum_in   [LANES];
   part_lane_type        part_ff  [LANES];
   part_lane_type        part_in  [LANES];
   wide_lane_type        wide_ff  [LANES];
   wide_lane_type        wide_in  [LANES];
   rsp_item_type         rsp_ff;
   rsp_item_type         rsp_in;

   logic signed [COORD_BITS-1:0] px [LANES];
   logic signed [COORD_BITS-1:0] py [LANES];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // clearance register and its square
   always_ff @(posedge clock) begin
      if (reset) begin
         clearance_ff <= CLR_RESET;
      end else if (csr_valid && csr_ready) begin
         clearance_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      clr_sq_ff <= C2_W'(clearance_ff) * C2_W'(clearance_ff);
   end

   // valid bits travel with the items
   assign valid_in = {valid_ff[DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: endpoint differences and identity check
   always_comb begin
      px[0] = req_item.first_start_x;  py[0] = req_item.first_start_y;
      px[1] = req_item.first_end_x;    py[1] = req_item.first_end_y;
      px[2] = req_item.second_start_x; py[2] = req_item.second_start_y;
      px[3] = req_item.second_end_x;   py[3] = req_item.second_end_y;
      ident1_in = ((px[0] == px[2]) && (py[0] == py[2]) &&
                   (px[1] == px[3]) && (py[1] == py[3])) ||
                  ((px[0] == px[3]) && (py[0] == py[3]) &&
                   (px[1] == px[2]) && (py[1] == py[2]));
      for (int k = 0; k < LANES; k++) begin
         diff_in[k].cx = DW'(px[LANE_E[k]]) - DW'(px[LANE_S[k]]);
         diff_in[k].cy = DW'(py[LANE_E[k]]) - DW'(py[LANE_S[k]]);
         diff_in[k].wx = DW'(px[LANE_P[k]]) - DW'(px[LANE_S[k]]);
         diff_in[k].wy = DW'(py[LANE_P[k]]) - DW'(py[LANE_S[k]]);
         diff_in[k].vx = DW'(px[LANE_P[k]]) - DW'(px[LANE_E[k]]);
         diff_in[k].vy = DW'(py[LANE_P[k]]) - DW'(py[LANE_E[k]]);
      end
   end

   // stage 2: products of differences
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         prod_in[k].dxx = PW'(diff_ff[k].wx) * PW'(diff_ff[k].cx);
         prod_in[k].dyy = PW'(diff_ff[k].wy) * PW'(diff_ff[k].cy);
         prod_in[k].lxx = PW'(diff_ff[k].cx) * PW'(diff_ff[k].cx);
         prod_in[k].lyy = PW'(diff_ff[k].cy) * PW'(diff_ff[k].cy);
         prod_in[k].wxx = PW'(diff_ff[k].wx) * PW'(diff_ff[k].wx);
         prod_in[k].wyy = PW'(diff_ff[k].wy) * PW'(diff_ff[k].wy);
         prod_in[k].vxx = PW'(diff_ff[k].vx) * PW'(diff_ff[k].vx);
         prod_in[k].vyy = PW'(diff_ff[k].vy) * PW'(diff_ff[k].vy);
         prod_in[k].crx = PW'(diff_ff[k].wx) * PW'(diff_ff[k].cy);
         prod_in[k].cry = PW'(diff_ff[k].wy) * PW'(diff_ff[k].cx);
      end
   end

   // stage 3: dot product, squared lengths, cross product
   always_comb begin
      logic signed [SW-1:0] len_s, dw_s, dv_s;
      for (int k = 0; k < LANES; k++) begin
         len_s = SW'(prod_ff[k].lxx) + SW'(prod_ff[k].lyy);
         dw_s  = SW'(prod_ff[k].wxx) + SW'(prod_ff[k].wyy);
         dv_s  = SW'(prod_ff[k].vxx) + SW'(prod_ff[k].vyy);
         sum_in[k].dot   = SW'(prod_ff[k].dxx) + SW'(prod_ff[k].dyy);
         sum_in[k].len   = len_s[PW-1:0];
         sum_in[k].dw    = dw_s[PW-1:0];
         sum_in[k].dv    = dv_s[PW-1:0];
         sum_in[k].cprod = SW'(prod_ff[k].crx) - SW'(prod_ff[k].cry);
      end
   end

   // stage 4: endpoint distance test, split squaring for the projection case
   always_comb begin
      logic                 near_start, near_end;
      logic [PW-1:0]        near_sq;
      logic signed [SW-1:0] cabs_s;
      logic [PW-1:0]        cabs;
      logic [DW-1:0]        mh, ml, lh, lo;
      logic [LANES-1:0]     neg, nz;
      for (int k = 0; k < LANES; k++) begin
         near_start = (sum_ff[k].len == '0) || sum_ff[k].dot[SW-1];
         near_end   = sum_ff[k].dot > $signed({1'b0, sum_ff[k].len});
         near_sq    = near_start ? sum_ff[k].dw : sum_ff[k].dv;
         part_in[k].proj  = !near_start && !near_end;
         part_in[k].close = DQ_W'(near_sq) < DQ_W'(clr_sq_ff);
         cabs_s = sum_ff[k].cprod[SW-1] ? -sum_ff[k].cprod : sum_ff[k].cprod;
         cabs   = cabs_s[PW-1:0];
         mh = cabs[PW-1:DW];
         ml = cabs[DW-1:0];
         lh = sum_ff[k].len[PW-1:DW];
         lo = sum_ff[k].len[DW-1:0];
         part_in[k].hh = HPW'(mh) * HPW'(mh);
         part_in[k].hl = HPW'(mh) * HPW'(ml);
         part_in[k].ll = HPW'(ml) * HPW'(ml);
         part_in[k].ch = CPW'(clr_sq_ff) * CPW'(lh);
         part_in[k].cl = CPW'(clr_sq_ff) * CPW'(lo);
         neg[k] = sum_ff[k].cprod[SW-1];
         nz[k]  = sum_ff[k].cprod != '0;
      end
      // lanes 2/3 give the sides of a and b, lanes 0/1 those of c and d
      proper4_in = nz[0] && nz[1] && (neg[0] != neg[1]) &&
                   nz[2] && nz[3] && (neg[2] != neg[3]);
   end

   // stage 5: assemble the squared cross product and the clearance bound
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         wide_in[k].lhs   = (LW'(part_ff[k].hh) << PW) +
                            (LW'(part_ff[k].hl) << (DW + 1)) +
                            LW'(part_ff[k].ll);
         wide_in[k].rhs   = (RW'(part_ff[k].ch) << DW) + RW'(part_ff[k].cl);
         wide_in[k].proj  = part_ff[k].proj;
         wide_in[k].close = part_ff[k].close;
      end
   end

   // stage 6: final compare and verdict
   always_comb begin
      logic too_close;
      too_close = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         if (wide_ff[k].proj) begin
            too_close = too_close || (CW'(wide_ff[k].lhs) < CW'(wide_ff[k].rhs));
         end else begin
            too_close = too_close || wide_ff[k].close;
         end
      end
      if (ident5_ff) begin
         rsp_in.verdict = VERDICT_IDENT;
      end else if (too_close) begin
         rsp_in.verdict = VERDICT_CLEAR;
      end else if (proper5_ff) begin
         rsp_in.verdict = VERDICT_CROSS;
      end else begin
         rsp_in.verdict = VERDICT_NONE;
      end
      rsp_in.crosses = rsp_in.verdict == VERDICT_CROSS;
   end

   // payload registers
   always_ff @(posedge clock) begin
      ident1_ff  <= ident1_in;
      ident2_ff  <= ident1_ff;
      ident3_ff  <= ident2_ff;
      ident4_ff  <= ident3_ff;
      ident5_ff  <= ident4_ff;
      proper4_ff <= proper4_in;
      proper5_ff <= proper4_ff;
      diff_ff    <= diff_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      part_ff    <= part_in;
      wide_ff    <= wide_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = valid_ff[DEPTH-1];
   assign rsp_item   = rsp_ff;

`ifndef ASSERT_OFF
   // every accepted item yields a result after the pipeline depth
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_strobe)
      else $error("accepted item gave no result");

   // no result appears without an item taken the pipeline depth before
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 6))
      else $error("result without an accepted item");

   // zero clearance never rejects on distance
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (clr_sq_ff == '0)) |-> (rsp_item.verdict != VERDICT_CLEAR))
      else $error("clearance verdict with zero clearance");
`endif

endmodule
